/* rtl/esmf_pkg.sv */
// ----------------------------------------------------------------------------
// esmf_pkg
// Shared types, constants and helpers of the edge shrinking median filter.
// ----------------------------------------------------------------------------
package esmf_pkg;

  localparam int SampleW          = 16;
  localparam int CntW             = 4;
  localparam int MaxWindowDefault = 15;
  // wide enough for any store index up to the largest allowed window
  localparam int QIdxW            = 5;

  typedef enum logic [1:0] {
    SelBypass = 2'd0,
    SelWin7   = 2'd1,
    SelWin11  = 2'd2,
    SelWin15  = 2'd3
  } win_sel_e;

  // window bounds handed to the rank unit
  typedef struct packed {
    logic [QIdxW-1:0] lo;
    logic [QIdxW-1:0] hi;
    logic [CntW-1:0]  half;
  } rank_query_t;

  function automatic logic [CntW-1:0] half_of_select(input logic [1:0] sel);
    logic [CntW-1:0] h;
    case (win_sel_e'(sel))
      SelBypass: h = 4'd0;
      SelWin7:   h = 4'd3;
      SelWin11:  h = 4'd5;
      SelWin15:  h = 4'd7;
      default:   h = 4'd0;
    endcase
    return h;
  endfunction

endpackage

/* rtl/esmf_ifs.sv */
// ----------------------------------------------------------------------------
// esmf input and output channels
// Valid/ready channels carrying one sample word in and one result word out.
// ----------------------------------------------------------------------------
interface esmf_in_if;
  logic                         valid;
  logic                         ready;
  logic [esmf_pkg::SampleW-1:0] sample;
  logic                         last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface esmf_out_if;
  logic                         valid;
  logic                         ready;
  logic [esmf_pkg::SampleW-1:0] filtered;
  logic                         end_mark;

  modport source (output valid, filtered, end_mark, input ready);
  modport sink   (input valid, filtered, end_mark, output ready);
endinterface

/* rtl/esmf_window_store.sv */
// ----------------------------------------------------------------------------
// esmf_window_store
// Sample shift line, newest at entry 0, with one selectable read port.
// ----------------------------------------------------------------------------
module esmf_window_store #(
  parameter int MAX_WINDOW = esmf_pkg::MaxWindowDefault,
  localparam int IdxW      = $clog2(MAX_WINDOW)
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [esmf_pkg::SampleW-1:0] sample_i,
  input  logic [IdxW-1:0]              rd_idx_i,
  output logic [esmf_pkg::SampleW-1:0] entries_o [MAX_WINDOW],
  output logic [esmf_pkg::SampleW-1:0] rd_data_o
);

  logic [esmf_pkg::SampleW-1:0] store_q [MAX_WINDOW];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      store_q[0] <= sample_i;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        store_q[i] <= store_q[i-1];
      end
    end
  end

  always_comb begin
    rd_data_o = store_q[0];
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (rd_idx_i == IdxW'(i)) begin
        rd_data_o = store_q[i];
      end
    end
  end

  assign entries_o = store_q;

endmodule

/* rtl/esmf_rank_unit.sv */
// ----------------------------------------------------------------------------
// esmf_rank_unit
// Ranks one candidate against every window entry and flags the median.
// ----------------------------------------------------------------------------
module esmf_rank_unit #(
  parameter int MAX_WINDOW = esmf_pkg::MaxWindowDefault
) (
  input  logic [esmf_pkg::SampleW-1:0] entries_i [MAX_WINDOW],
  input  logic [esmf_pkg::SampleW-1:0] cand_i,
  input  esmf_pkg::rank_query_t        query_i,
  output logic                         hit_o
);

  localparam int CntBits = $clog2(MAX_WINDOW + 1);
  localparam int CmpW    = (CntBits > esmf_pkg::CntW) ? CntBits : esmf_pkg::CntW;

  logic [CntBits-1:0] less;
  logic [CntBits-1:0] equal;
  logic [CmpW-1:0]    less_x;
  logic [CmpW-1:0]    upper_x;
  logic [CmpW-1:0]    half_x;

  always_comb begin
    less  = '0;
    equal = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (esmf_pkg::QIdxW'(k) >= query_i.lo && esmf_pkg::QIdxW'(k) <= query_i.hi) begin
        if (entries_i[k] < cand_i) begin
          less = less + CntBits'(1);
        end else if (entries_i[k] == cand_i) begin
          equal = equal + CntBits'(1);
        end
      end
    end
  end

  assign less_x  = CmpW'(less);
  assign upper_x = CmpW'(less) + CmpW'(equal);
  assign half_x  = CmpW'(query_i.half);
  assign hit_o   = (less_x <= half_x) && (half_x < upper_x);

endmodule

/* rtl/edge_shrinking_median_filter.sv */
// ----------------------------------------------------------------------------
// edge_shrinking_median_filter
// Running median over a centered window of 7, 11 or 15 samples (1 in bypass)
// that shrinks symmetrically at sequence ends; a last sample flushes the rest.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   sample[15:0], last
//  out_o     out  valid/ready   filtered[15:0], end_mark
//  cfg       in   cfg_we_i      cfg_data_i[1:0] (window_select)
//
//  one sample: an accept in StIdle, then per result a setup in StPick and a
//  scan of 1 to 2h+1 candidates on the shared rank unit (h = half window, at
//  most 7), then a closing check; a last sample gives up to 8 results
//  ready only while idle; a result waiting in the output register stalls
//  the rank unit but not the next accept
//  async active-low reset clears control state; no clearing pass
// ----------------------------------------------------------------------------
module edge_shrinking_median_filter #(
  parameter int MAX_WINDOW = esmf_pkg::MaxWindowDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  esmf_in_if.sink    in_i,
  esmf_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i
);

  localparam int IdxW = $clog2(MAX_WINDOW);
  localparam int CntW = esmf_pkg::CntW;
  localparam logic [CntW-1:0] Cap = CntW'((MAX_WINDOW - 1) / 2);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StPick = 3'b010,
    StScan = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [1:0]      sel_q;
  logic [CntW-1:0] seen_q, seen_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic            last_q, last_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] cand_q, cand_d;
  esmf_pkg::rank_query_t query_q, query_d;

  logic                         out_valid_q, out_valid_d;
  logic [esmf_pkg::SampleW-1:0] out_data_q, out_data_d;
  logic                         out_end_q, out_end_d;

  logic                         accept;
  logic                         hit;
  logic                         load;
  logic [esmf_pkg::SampleW-1:0] cand_val;
  logic [esmf_pkg::SampleW-1:0] entries [MAX_WINDOW];

  logic [CntW-1:0] h_sel, h_cur, pos, older, h_a, h_pos;
  logic            need;

  esmf_window_store #(.MAX_WINDOW(MAX_WINDOW)) u_store (
    .clk_i    (clk_i),
    .shift_i  (accept),
    .sample_i (in_i.sample),
    .rd_idx_i (cand_q),
    .entries_o(entries),
    .rd_data_o(cand_val)
  );

  esmf_rank_unit #(.MAX_WINDOW(MAX_WINDOW)) u_rank (
    .entries_i(entries),
    .cand_i   (cand_val),
    .query_i  (query_q),
    .hit_o    (hit)
  );

  assign in_i.ready     = (state_q == StIdle);
  assign accept         = in_i.valid && in_i.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_data_q;
  assign out_o.end_mark = out_end_q;

  // half window for the next word to give back
  assign h_sel  = esmf_pkg::half_of_select(sel_q);
  assign h_cur  = (h_sel < Cap) ? h_sel : Cap;
  assign pos    = emitted_q - CntW'(1);
  assign older  = (seen_q > pos) ? (seen_q - CntW'(1) - pos) : '0;
  assign h_a    = (older < h_cur) ? older : h_cur;
  assign h_pos  = (pos < h_a) ? pos : h_a;
  assign need   = last_q ? (emitted_q != '0) : (emitted_q > h_cur);
  assign load   = (state_q == StScan) && hit && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    emitted_d   = emitted_q;
    last_d      = last_q;
    pos_d       = pos_q;
    cand_d      = cand_q;
    query_d     = query_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_end_d   = out_end_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          seen_d    = (seen_q != '1) ? seen_q + CntW'(1) : seen_q;
          emitted_d = (emitted_q != '1) ? emitted_q + CntW'(1) : emitted_q;
          last_d    = in_i.last;
          state_d   = StPick;
        end
      end
      StPick: begin
        if (need) begin
          query_d.lo   = esmf_pkg::QIdxW'(pos) - esmf_pkg::QIdxW'(h_pos);
          query_d.hi   = esmf_pkg::QIdxW'(pos) + esmf_pkg::QIdxW'(h_pos);
          query_d.half = h_pos;
          cand_d       = IdxW'(pos - h_pos);
          pos_d        = pos;
          state_d      = StScan;
        end else begin
          if (last_q) begin
            seen_d = '0;
          end
          state_d = StIdle;
        end
      end
      StScan: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_data_d  = cand_val;
          out_end_d   = last_q && (pos_q == '0);
          emitted_d   = emitted_q - CntW'(1);
          state_d     = StPick;
        end else if (!hit) begin
          cand_d = cand_q + IdxW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= esmf_pkg::SelWin7;
      seen_q      <= '0;
      emitted_q   <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      emitted_q   <= emitted_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sel_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cand_q     <= cand_d;
    query_q    <= query_d;
    out_data_q <= out_data_d;
    out_end_q  <= out_end_d;
  end

`ifndef SYNTHESIS
  // the candidate scan always stops inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> esmf_pkg::QIdxW'(cand_q) <= query_q.hi)
    else $error("median candidate ran past the window");

  // never more words held than the widest half window plus the new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= Cap + CntW'(1))
    else $error("held word count out of range");

  // each word given back retires exactly one held sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> emitted_q == $past(emitted_q) - CntW'(1))
    else $error("held count not decremented on output");

  // a new output word only comes from the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StScan))
    else $error("output word loaded outside the scan");
`endif

endmodule
